### rtl/dms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types, codes and constants for the depth mission sequencer.
// ----------------------------------------------------------------------------
package dms_pkg;

    // stream payload, field and configuration widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 8;
    localparam int REQ_W      = 3;
    localparam int TICK_W     = 32;
    localparam int DEPTH_W    = 24;
    localparam int VEL_W      = 16;
    localparam int PHASE_W    = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TARGET_W   = 23;
    localparam int BAND_W     = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RECOVER = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ABORT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ACK     = 3'd4;

    // mission phases
    localparam logic [PHASE_W-1:0] PH_INIT     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_WATER    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_APPROACH = 4'd2;
    localparam logic [PHASE_W-1:0] PH_PREP     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_HOLD     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_DWELL    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ASCEND   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_SHUTDOWN = 4'd7;
    localparam logic [PHASE_W-1:0] PH_FAILSAFE = 4'd8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_DEPTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BAND_ENTER     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BAND_EXIT      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WATER_THR      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SURFACE_DEPTH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_WATER_TIMEOUT  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_DWELL     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECOVERY_DELAY = 3'd7;

    localparam logic signed [VEL_W-1:0] VEL_NEAR_ZERO    = 16'sd50;
    localparam logic [TICK_W-1:0]       ASCEND_MIN_TICKS = 32'd200;

    typedef struct packed {
        logic [TARGET_W-1:0] target_depth;
        logic [BAND_W-1:0]   band_enter;
        logic [BAND_W-1:0]   band_exit;
        logic [BAND_W-1:0]   water_thr;
        logic [BAND_W-1:0]   surface_depth;
        logic [TICK_W-1:0]   water_timeout;
        logic [TICK_W-1:0]   hold_dwell;
        logic [TICK_W-1:0]   recovery_delay;
    } t_cfg;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [TICK_W-1:0]  tick_stamp;
        logic [DEPTH_W-1:0] depth_mm;
        logic [VEL_W-1:0]   velocity_mmps;
        logic               buoy_steady;
    } t_req;

    typedef struct packed {
        logic [PHASE_W-1:0] mission_state;
        logic               state_changed;
        logic               running;
    } t_result;

endpackage

### rtl/dms_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dms_core
// Mission phase machine: holds the sequencer state and works out the next
// state and the result for one request.
// ----------------------------------------------------------------------------
module dms_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  dms_pkg::t_req    i_req,
    input  dms_pkg::t_cfg    i_cfg,
    output dms_pkg::t_result o_result
);
    import dms_pkg::*;

    logic               r_started;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] r_prev;
    logic [TICK_W-1:0]  r_entry;
    logic [TICK_W-1:0]  r_inband_start;
    logic               r_inband;

    logic               n_started;
    logic [PHASE_W-1:0] n_phase;
    logic [PHASE_W-1:0] n_prev;
    logic [TICK_W-1:0]  n_entry;
    logic [TICK_W-1:0]  n_inband_start;
    logic               n_inband;

    logic               go;
    logic [PHASE_W-1:0] go_phase;

    logic signed [DEPTH_W:0] depth_x;
    logic signed [DEPTH_W:0] dz;
    logic [DEPTH_W:0]        err;
    logic                    in_enter;
    logic                    out_exit;
    logic                    vel_small;
    logic [TICK_W-1:0]       since_entry;
    logic [TICK_W-1:0]       since_inband;
    logic                    hold_timing;
    logic [TICK_W-1:0]       hold_start;

    always_comb begin
        depth_x     = $signed({i_req.depth_mm[DEPTH_W-1], i_req.depth_mm});
        dz          = depth_x - $signed({2'b00, i_cfg.target_depth});
        err         = dz[DEPTH_W] ? (DEPTH_W+1)'(0) - dz : dz;
        in_enter    = err <= {{(DEPTH_W+1-BAND_W){1'b0}}, i_cfg.band_enter};
        out_exit    = err > {{(DEPTH_W+1-BAND_W){1'b0}}, i_cfg.band_exit};
        vel_small   = ($signed(i_req.velocity_mmps) > -VEL_NEAR_ZERO) &&
                      ($signed(i_req.velocity_mmps) < VEL_NEAR_ZERO);
        since_entry = i_req.tick_stamp - r_entry;
        // in-band timer as it stands after this sample, before the dwell test
        hold_timing = in_enter;
        hold_start  = r_inband ? r_inband_start : i_req.tick_stamp;
        since_inband = i_req.tick_stamp - hold_start;
    end

    always_comb begin
        n_started      = r_started;
        n_phase        = r_phase;
        n_prev         = r_prev;
        n_entry        = r_entry;
        n_inband_start = r_inband_start;
        n_inband       = r_inband;
        go             = 1'b0;
        go_phase       = r_phase;

        case (i_req.req_type)
            REQ_UPDATE: begin
                if (r_started) begin
                    case (r_phase)
                        PH_INIT: begin
                            go       = 1'b1;
                            go_phase = PH_WATER;
                        end
                        PH_WATER: begin
                            if (depth_x > $signed({9'b0, i_cfg.water_thr})) begin
                                go       = 1'b1;
                                go_phase = PH_APPROACH;
                            end else if (since_entry > i_cfg.water_timeout) begin
                                go       = 1'b1;
                                go_phase = PH_FAILSAFE;
                            end
                        end
                        PH_APPROACH: begin
                            if (in_enter) begin
                                go       = 1'b1;
                                go_phase = PH_PREP;
                            end
                        end
                        PH_PREP: begin
                            if (out_exit) begin
                                go       = 1'b1;
                                go_phase = PH_APPROACH;
                            end else if (i_req.buoy_steady && vel_small) begin
                                go       = 1'b1;
                                go_phase = PH_HOLD;
                            end
                        end
                        PH_HOLD: begin
                            if (out_exit) begin
                                n_inband = 1'b0;
                                go       = 1'b1;
                                go_phase = PH_APPROACH;
                            end else begin
                                n_inband       = hold_timing;
                                n_inband_start = in_enter ? hold_start : r_inband_start;
                                if (hold_timing && since_inband >= i_cfg.hold_dwell) begin
                                    n_inband = 1'b0;
                                    go       = 1'b1;
                                    go_phase = PH_DWELL;
                                end
                            end
                        end
                        PH_DWELL: begin
                            if (out_exit) begin
                                go       = 1'b1;
                                go_phase = PH_APPROACH;
                            end else if (!in_enter) begin
                                go       = 1'b1;
                                go_phase = PH_HOLD;
                            end else if (since_entry >= i_cfg.recovery_delay) begin
                                go       = 1'b1;
                                go_phase = PH_ASCEND;
                            end
                        end
                        PH_ASCEND: begin
                            if (since_entry >= ASCEND_MIN_TICKS &&
                                depth_x <= $signed({9'b0, i_cfg.surface_depth})) begin
                                go       = 1'b1;
                                go_phase = PH_SHUTDOWN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            REQ_START: begin
                n_phase   = PH_INIT;
                n_prev    = PH_INIT;
                n_entry   = '0;
                n_started = 1'b1;
            end
            REQ_RECOVER: begin
                go       = 1'b1;
                go_phase = PH_ASCEND;
            end
            REQ_ABORT: begin
                go       = 1'b1;
                go_phase = PH_FAILSAFE;
            end
            REQ_ACK: begin
                n_prev = r_phase;
            end
            default: begin
            end
        endcase

        if (go) begin
            n_prev  = r_phase;
            n_phase = go_phase;
            n_entry = i_req.tick_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started      <= 1'b0;
            r_phase        <= PH_INIT;
            r_prev         <= PH_INIT;
            r_entry        <= '0;
            r_inband_start <= '0;
            r_inband       <= 1'b0;
        end else if (i_en) begin
            r_started      <= n_started;
            r_phase        <= n_phase;
            r_prev         <= n_prev;
            r_entry        <= n_entry;
            r_inband_start <= n_inband_start;
            r_inband       <= n_inband;
        end
    end

    assign o_result.mission_state = n_phase;
    assign o_result.state_changed = n_prev != n_phase;
    assign o_result.running       = n_started;

endmodule

### rtl/depth_mission_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_mission_sequencer
// Mission sequencer for a depth-holding vehicle: one result per request.
//
//   channel  dir  handshake              payload
//   s        in   i_s_tvalid/o_s_tready  tdata: tick, depth, velocity, stable
//                                        tuser: request type
//   m        out  o_m_tvalid/i_m_tready  tdata: state, changed, running
//   cfg      in   i_cfg_valid/o_cfg_ready index + 32-bit data
//
// One request per cycle sustained while the output is ready; each request passes
// through the input register, then the phase machine into the result register.
// The phase state updates in order as each request leaves the input register.
// A stalled output holds both registers; the input side takes a new transfer
// whenever the input register empties. Synchronous active-low reset; the
// config port is always ready.
// ----------------------------------------------------------------------------
module depth_mission_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [31:0] tick_stamp, [55:32] depth_mm, [71:56] velocity_mmps,
    // [72] buoy_steady, [79:73] zero
    input  logic [dms_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // [2:0] req_type
    input  logic [dms_pkg::REQ_W-1:0]           i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [3:0] mission_state, [4] state_changed, [5] running, [7:6] zero
    output logic [dms_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dms_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [dms_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dms_pkg::*;

    logic    r_in_vld;
    t_req    r_in;
    logic    r_out_vld;
    t_result r_out;
    t_cfg    r_cfg;

    logic    advance;
    logic    in_xfer;
    t_result core_result;

    assign advance     = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready  = !r_in_vld || advance;
    assign in_xfer     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.req_type      <= i_s_tuser;
            r_in.tick_stamp    <= i_s_tdata[31:0];
            r_in.depth_mm      <= i_s_tdata[55:32];
            r_in.velocity_mmps <= i_s_tdata[71:56];
            r_in.buoy_steady   <= i_s_tdata[72];
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_depth   <= 23'd0;
            r_cfg.band_enter     <= 16'd500;
            r_cfg.band_exit      <= 16'd1000;
            r_cfg.water_thr      <= 16'd300;
            r_cfg.surface_depth  <= 16'd500;
            r_cfg.water_timeout  <= 32'd60000;
            r_cfg.hold_dwell     <= 32'd10000;
            r_cfg.recovery_delay <= 32'd60000;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_TARGET_DEPTH:   r_cfg.target_depth   <= i_cfg_data[TARGET_W-1:0];
                CFG_BAND_ENTER:     r_cfg.band_enter     <= i_cfg_data[BAND_W-1:0];
                CFG_BAND_EXIT:      r_cfg.band_exit      <= i_cfg_data[BAND_W-1:0];
                CFG_WATER_THR:      r_cfg.water_thr      <= i_cfg_data[BAND_W-1:0];
                CFG_SURFACE_DEPTH:  r_cfg.surface_depth  <= i_cfg_data[BAND_W-1:0];
                CFG_WATER_TIMEOUT:  r_cfg.water_timeout  <= i_cfg_data;
                CFG_HOLD_DWELL:     r_cfg.hold_dwell     <= i_cfg_data;
                CFG_RECOVERY_DELAY: r_cfg.recovery_delay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_req    (r_in),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out.running, r_out.state_changed, r_out.mission_state};

endmodule

### tb/depth_mission_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_mission_sequencer_tb
// Self-checking bench for the depth mission sequencer. A clocked driver sends
// requests from a pending queue and a clocked monitor checks every result
// against a phase-machine predictor kept in step at each input transfer.
// Directed boundary cases come first, then random mission sequences under
// several register settings and idling mixes, with a long output stall.
// ----------------------------------------------------------------------------
module depth_mission_sequencer_tb;
    import dms_pkg::*;

    localparam int     CYCLE_LIMIT  = 300000;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     HOLD_CYCLES  = 60;
    localparam longint DEPTH_MAX    = 8388607;
    localparam longint DEPTH_MIN    = -8388608;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic [REQ_W-1:0]      i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    depth_mission_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and scoreboard state
    t_req        pending_requests[$];
    t_result     expected_results[$];
    t_req        in_flight;
    t_req        next_req;
    t_result     want;
    int          n_queued     = 0;
    int          n_accepted   = 0;
    int          n_errors     = 0;
    int          src_idle_pct = 29;
    int          snk_idle_pct = 82;
    int          stall_reqs   = 0;
    int          stall_done   = 0;
    int          hold_left    = 0;
    int          cycle_count  = 0;
    logic [31:0] gen_tick     = 32'hFFFF_0000;

    // predictor copy of registers and mission state
    t_cfg        cfg_model;
    logic        run_started = 1'b0;
    logic [3:0]  cur_phase   = PH_INIT;
    logic [3:0]  prev_phase  = PH_INIT;
    logic [31:0] entry_tick  = '0;
    logic [31:0] inband_tick = '0;
    logic        inband_on   = 1'b0;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    function automatic void enter_phase(input logic [3:0] nxt, input logic [31:0] now);
        prev_phase = cur_phase;
        cur_phase  = nxt;
        entry_tick = now;
    endfunction

    function automatic t_result step_mission(input t_req r);
        t_result           res;
        logic signed [23:0] d24;
        logic signed [15:0] v16;
        longint            depth, err, avel, vnz;
        longint            target, b_in, b_out, thr, surf;
        logic [31:0]       now, since_entry, since_inband;
        d24    = r.depth_mm;
        v16    = r.velocity_mmps;
        depth  = d24;
        avel   = (v16 < 0) ? -longint'(v16) : longint'(v16);
        vnz    = VEL_NEAR_ZERO;
        target = cfg_model.target_depth;
        b_in   = cfg_model.band_enter;
        b_out  = cfg_model.band_exit;
        thr    = cfg_model.water_thr;
        surf   = cfg_model.surface_depth;
        err    = depth - target;
        if (err < 0)
            err = -err;
        now         = r.tick_stamp;
        since_entry = now - entry_tick;
        case (r.req_type)
            REQ_UPDATE: begin
                if (run_started) begin
                    case (cur_phase)
                        PH_INIT: enter_phase(PH_WATER, now);
                        PH_WATER: begin
                            if (depth > thr)
                                enter_phase(PH_APPROACH, now);
                            else if (since_entry > cfg_model.water_timeout)
                                enter_phase(PH_FAILSAFE, now);
                        end
                        PH_APPROACH: begin
                            if (err <= b_in)
                                enter_phase(PH_PREP, now);
                        end
                        PH_PREP: begin
                            if (err > b_out)
                                enter_phase(PH_APPROACH, now);
                            else if (r.buoy_steady && avel < vnz)
                                enter_phase(PH_HOLD, now);
                        end
                        PH_HOLD: begin
                            if (err > b_out) begin
                                inband_on = 1'b0;
                                enter_phase(PH_APPROACH, now);
                            end else begin
                                if (err <= b_in) begin
                                    if (!inband_on) begin
                                        inband_on   = 1'b1;
                                        inband_tick = now;
                                    end
                                end else begin
                                    inband_on = 1'b0;
                                end
                                since_inband = now - inband_tick;
                                if (inband_on && since_inband >= cfg_model.hold_dwell) begin
                                    enter_phase(PH_DWELL, now);
                                    inband_on = 1'b0;
                                end
                            end
                        end
                        PH_DWELL: begin
                            if (err > b_out)
                                enter_phase(PH_APPROACH, now);
                            else if (err > b_in)
                                enter_phase(PH_HOLD, now);
                            else if (since_entry >= cfg_model.recovery_delay)
                                enter_phase(PH_ASCEND, now);
                        end
                        PH_ASCEND: begin
                            if (since_entry >= ASCEND_MIN_TICKS && depth <= surf)
                                enter_phase(PH_SHUTDOWN, now);
                        end
                        default: ;
                    endcase
                end
            end
            REQ_START: begin
                cur_phase   = PH_INIT;
                prev_phase  = PH_INIT;
                entry_tick  = '0;
                run_started = 1'b1;
            end
            REQ_RECOVER: enter_phase(PH_ASCEND, now);
            REQ_ABORT:   enter_phase(PH_FAILSAFE, now);
            REQ_ACK:     prev_phase = cur_phase;
            default: ;
        endcase
        res.mission_state = cur_phase;
        res.state_changed = (prev_phase != cur_phase);
        res.running       = run_started;
        return res;
    endfunction

    // ---------------- driver: request stream ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(step_mission(in_flight));
                n_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    next_req   = pending_requests.pop_front();
                    in_flight  = next_req;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {7'd0, next_req.buoy_steady, next_req.velocity_mmps,
                                   next_req.depth_mm, next_req.tick_stamp};
                    i_s_tuser  <= next_req.req_type;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result side: ready and long hold-offs ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (stall_done != stall_reqs) begin
            i_m_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            stall_done <= stall_done + 1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                flag_error($sformatf("result transfer with nothing expected, tdata %h",
                                     o_m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (o_m_tdata[3:0] !== want.mission_state)
                    flag_error($sformatf("mission_state %0d, expected %0d",
                                         o_m_tdata[3:0], want.mission_state));
                if (o_m_tdata[4] !== want.state_changed)
                    flag_error($sformatf("state_changed %b, expected %b",
                                         o_m_tdata[4], want.state_changed));
                if (o_m_tdata[5] !== want.running)
                    flag_error($sformatf("running %b, expected %b",
                                         o_m_tdata[5], want.running));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic void push_req(input logic [REQ_W-1:0] req, input logic [31:0] tick,
                                     input logic [23:0] depth, input logic [15:0] vel,
                                     input logic stable);
        t_req r;
        r.req_type      = req;
        r.tick_stamp    = tick;
        r.depth_mm      = depth;
        r.velocity_mmps = vel;
        r.buoy_steady   = stable;
        pending_requests.push_back(r);
        n_queued++;
    endfunction

    function automatic logic [31:0] next_tick();
        gen_tick += $urandom_range(0, 15);
        return gen_tick;
    endfunction

    function automatic logic [23:0] depth_clip(input longint v);
        longint c;
        c = (v > DEPTH_MAX) ? DEPTH_MAX : (v < DEPTH_MIN) ? DEPTH_MIN : v;
        return c[23:0];
    endfunction

    // depth whose error from the target lies in [lo, hi]
    function automatic logic [23:0] depth_at_error(input longint lo, input longint hi);
        longint err, d;
        err = lo + $urandom_range(0, int'(hi - lo));
        d   = cfg_model.target_depth;
        if ($urandom_range(0, 1) == 1 || d + err > DEPTH_MAX)
            d = d - err;
        else
            d = d + err;
        return depth_clip(d);
    endfunction

    // outside the enter band but still inside the exit band where possible
    function automatic logic [23:0] depth_between_bands();
        longint b_in, b_out;
        b_in  = cfg_model.band_enter;
        b_out = cfg_model.band_exit;
        if (b_in < b_out)
            return depth_at_error(b_in + 1, b_out);
        return depth_at_error(b_out + 1, b_out + 2000);
    endfunction

    function automatic logic [15:0] calm_vel();
        int lim;
        lim = VEL_NEAR_ZERO - 1;
        return 16'($urandom_range(0, 2 * lim) - lim);
    endfunction

    function automatic logic [15:0] restless_vel();
        int mag;
        mag = VEL_NEAR_ZERO + $urandom_range(0, 3000);
        return ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic add_noise(input int k);
        repeat (k)
            push_req(3'($urandom()), $urandom(), 24'($urandom()), 16'($urandom()),
                     1'($urandom()));
    endtask

    // one well-formed mission with random content and the odd detour
    task automatic add_mission();
        longint b_in, b_out, thr, surf;
        int     n;
        b_in  = cfg_model.band_enter;
        b_out = cfg_model.band_exit;
        thr   = cfg_model.water_thr;
        surf  = cfg_model.surface_depth;
        push_req(REQ_START, next_tick(), 24'($urandom()), 16'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 3) == 0)
            push_req(REQ_ACK, next_tick(), 24'($urandom()), 16'($urandom()), 1'($urandom()));
        n = $urandom_range(1, 3);
        repeat (n)
            push_req(REQ_UPDATE, next_tick(), depth_clip(thr - $urandom_range(0, 5000)),
                     16'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 7) == 0) begin
            // water never found
            gen_tick += cfg_model.water_timeout + 32'd1;
            push_req(REQ_UPDATE, next_tick(), depth_clip(thr - $urandom_range(0, 5000)),
                     16'($urandom()), 1'($urandom()));
            push_req(REQ_UPDATE, next_tick(), 24'($urandom()), 16'($urandom()), 1'($urandom()));
            return;
        end
        push_req(REQ_UPDATE, next_tick(), depth_clip(thr + 1 + $urandom_range(0, 5000)),
                 16'($urandom()), 1'($urandom()));
        n = $urandom_range(0, 2);
        repeat (n)
            push_req(REQ_UPDATE, next_tick(), depth_at_error(b_in + 1, b_in + 3000),
                     16'($urandom()), 1'($urandom()));
        push_req(REQ_UPDATE, next_tick(), depth_at_error(0, b_in), restless_vel(), 1'($urandom()));
        if ($urandom_range(0, 4) == 0) begin
            push_req(REQ_UPDATE, next_tick(), depth_at_error(b_out + 1, b_out + 3000),
                     16'($urandom()), 1'($urandom()));
            push_req(REQ_UPDATE, next_tick(), depth_at_error(0, b_in), restless_vel(), 1'b0);
        end
        n = $urandom_range(0, 2);
        repeat (n)
            push_req(REQ_UPDATE, next_tick(), depth_at_error(0, b_in),
                     ($urandom_range(0, 1) == 1) ? restless_vel() : calm_vel(), 1'b0);
        push_req(REQ_UPDATE, next_tick(), depth_at_error(0, b_in), calm_vel(), 1'b1);
        // holding at depth
        n = $urandom_range(1, 3);
        repeat (n)
            push_req(REQ_UPDATE, next_tick(),
                     ($urandom_range(0, 3) == 0) ? depth_between_bands()
                                                 : depth_at_error(0, b_in),
                     16'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 7) == 0) begin
            push_req(REQ_UPDATE, next_tick(), depth_at_error(b_out + 1, b_out + 3000),
                     16'($urandom()), 1'($urandom()));
            return;
        end
        push_req(REQ_UPDATE, next_tick(), depth_at_error(0, b_in), 16'($urandom()), 1'($urandom()));
        gen_tick += cfg_model.hold_dwell;
        push_req(REQ_UPDATE, next_tick(), depth_at_error(0, b_in), 16'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 5) == 0) begin
            push_req(REQ_UPDATE, next_tick(),
                     ($urandom_range(0, 1) == 1) ? depth_between_bands()
                                                 : depth_at_error(b_out + 1, b_out + 3000),
                     16'($urandom()), 1'($urandom()));
            return;
        end
        if ($urandom_range(0, 2) == 0)
            push_req(REQ_ACK, next_tick(), 24'($urandom()), 16'($urandom()), 1'($urandom()));
        gen_tick += cfg_model.recovery_delay;
        push_req(REQ_UPDATE, next_tick(), depth_at_error(0, b_in), 16'($urandom()), 1'($urandom()));
        // ascent, first too early then past the minimum time
        push_req(REQ_UPDATE, next_tick(), depth_clip(surf - $urandom_range(0, 3000)),
                 16'($urandom()), 1'($urandom()));
        gen_tick += ASCEND_MIN_TICKS;
        push_req(REQ_UPDATE, next_tick(), depth_clip(surf + 1 - $urandom_range(0, 3000)),
                 16'($urandom()), 1'($urandom()));
        push_req(REQ_UPDATE, next_tick(), depth_clip(surf - $urandom_range(0, 3000)),
                 16'($urandom()), 1'($urandom()));
        case ($urandom_range(0, 3))
            0: push_req(REQ_ACK, next_tick(), 24'($urandom()), 16'($urandom()), 1'($urandom()));
            1: push_req(REQ_ABORT, next_tick(), 24'($urandom()), 16'($urandom()), 1'($urandom()));
            2: push_req(REQ_RECOVER, next_tick(), 24'($urandom()), 16'($urandom()),
                        1'($urandom()));
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (n_accepted != n_queued || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // back-to-back register writes keep valid high between transfers
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_TARGET_DEPTH:   cfg_model.target_depth   = val[TARGET_W-1:0];
            CFG_BAND_ENTER:     cfg_model.band_enter     = val[BAND_W-1:0];
            CFG_BAND_EXIT:      cfg_model.band_exit      = val[BAND_W-1:0];
            CFG_WATER_THR:      cfg_model.water_thr      = val[BAND_W-1:0];
            CFG_SURFACE_DEPTH:  cfg_model.surface_depth  = val[BAND_W-1:0];
            CFG_WATER_TIMEOUT:  cfg_model.water_timeout  = val;
            CFG_HOLD_DWELL:     cfg_model.hold_dwell     = val;
            CFG_RECOVERY_DELAY: cfg_model.recovery_delay = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(CFG_TARGET_DEPTH,   32'(c.target_depth));
        write_reg(CFG_BAND_ENTER,     32'(c.band_enter));
        write_reg(CFG_BAND_EXIT,      32'(c.band_exit));
        write_reg(CFG_WATER_THR,      32'(c.water_thr));
        write_reg(CFG_SURFACE_DEPTH,  32'(c.surface_depth));
        write_reg(CFG_WATER_TIMEOUT,  c.water_timeout);
        write_reg(CFG_HOLD_DWELL,     c.hold_dwell);
        write_reg(CFG_RECOVERY_DELAY, c.recovery_delay);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cfg rand_config();
        t_cfg c;
        c.target_depth   = ($urandom_range(0, 3) == 0) ? 23'($urandom())
                                                       : 23'($urandom_range(0, 20000));
        c.band_enter     = 16'($urandom_range(0, 3000));
        c.band_exit      = 16'($urandom_range(0, 4000));
        c.water_thr      = 16'($urandom());
        c.surface_depth  = 16'($urandom());
        c.water_timeout  = $urandom_range(0, 2000);
        c.hold_dwell     = $urandom_range(0, 2000);
        c.recovery_delay = $urandom_range(0, 2000);
        return c;
    endfunction

    task automatic random_traffic(input int n);
        int first;
        first = n_queued;
        while (n_queued - first < n) begin
            if ($urandom_range(0, 99) < 80)
                add_mission();
            else
                add_noise($urandom_range(1, 4));
            // sender pause until every result is back
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // ---------------- test sequence ----------------
    initial begin : stimulus
        logic [31:0] t0, t1;
        cfg_model = {23'd0, 16'd500, 16'd1000, 16'd300, 16'd500,
                     32'd60000, 32'd10000, 32'd60000};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass with the reset register values
        t0 = 32'hFFFF_FF00;
        t1 = t0 + 32'h200;
        push_req(REQ_UPDATE, 32'hFFFF_FFFF, 24'h80_0000, 16'h8000, 1'b1);  // before start
        push_req(REQ_UNUSED, 32'h0, 24'h7F_FFFF, 16'h7FFF, 1'b0);
        push_req(REQ_RECOVER, 32'd5, 24'd0, 16'd0, 1'b0);
        push_req(REQ_START, 32'd6, 24'd0, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t0, 24'd0, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t0 + 32'd10, 24'd300, 16'd0, 1'b0);           // at threshold
        push_req(REQ_UPDATE, t0 + 32'd20, 24'd301, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t0 + 32'd30, 24'd501, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t0 + 32'd40, -24'd500, 16'd0, 1'b0);          // on enter band
        push_req(REQ_UPDATE, t0 + 32'd50, 24'd1001, 16'd0, 1'b0);          // past exit band
        push_req(REQ_UPDATE, t0 + 32'd60, 24'd500, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t0 + 32'd70, 24'd500, 16'd50, 1'b1);          // velocity not low
        push_req(REQ_UPDATE, t1, 24'd500, -16'd49, 1'b1);                  // tick wrapped
        push_req(REQ_UPDATE, t1, 24'd0, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t1 + 32'd5000, 24'd700, 16'd0, 1'b0);         // in-band timer cleared
        push_req(REQ_UPDATE, t1 + 32'd6000, 24'd100, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t1 + 32'd15999, 24'd100, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t1 + 32'd16000, 24'd100, 16'd0, 1'b0);        // dwell time exactly
        push_req(REQ_ACK, t1 + 32'd16001, 24'd0, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t1 + 32'd76000, 24'd0, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t1 + 32'd76199, 24'd500, 16'd0, 1'b0);        // ascent too short
        push_req(REQ_UPDATE, t1 + 32'd76201, 24'd500, 16'd0, 1'b0);
        push_req(REQ_ABORT, t1 + 32'd76300, 24'd0, 16'd0, 1'b0);
        push_req(REQ_UPDATE, t1 + 32'd76400, 24'd0, 16'd0, 1'b0);          // failsafe is sticky
        push_req(REQ_START, 32'd90, 24'd0, 16'd0, 1'b0);
        push_req(REQ_UPDATE, 32'd100, 24'd0, 16'd0, 1'b0);
        push_req(REQ_UPDATE, 32'd60101, 24'd0, 16'd0, 1'b0);               // water timeout
        wait_drained();

        src_idle_pct = 29;
        snk_idle_pct = 82;
        load_config({23'd5000, 16'd200, 16'd400, 16'd300, 16'd500,
                     32'd1000, 32'd300, 32'd500});
        random_traffic(80);
        load_config('1);
        random_traffic(70);

        src_idle_pct = 82;
        snk_idle_pct = 29;
        load_config('0);
        random_traffic(70);
        load_config(rand_config());
        random_traffic(80);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        load_config(rand_config());
        stall_reqs++;
        random_traffic(80);
        load_config(rand_config());
        random_traffic(80);

        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
